// File: hw/rtl/wrhv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhv_pkg
// Shared constants and controller/datapath interface types for the WAV RIFF
// header validator.
// ----------------------------------------------------------------------------
`default_nettype none

package wrhv_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [33:0] FIRST_CHUNK  = 34'd12;
  localparam logic [33:0] HDR_BYTES    = 34'd8;
  localparam logic [33:0] FMT_SPAN     = 34'd24;
  localparam logic [31:0] FMT_BYTES    = 32'd16;
  localparam logic [32:0] MIN_LAST_POS = 33'd43;
  localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;
  localparam logic [5:0]  MOD_STEPS    = 6'd32;

  localparam logic [1:0] PH_RIFF = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_FMT  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  localparam logic [1:0] VERD_NONE = 2'd0;
  localparam logic [1:0] VERD_DATA = 2'd1;
  localparam logic [1:0] VERD_FAIL = 2'd2;

  typedef struct packed {
    logic byte_en;
    logic fmt_s1;
    logic fmt_s2;
    logic finish;
  } wrhv_cmd_t;

  typedef struct packed {
    logic fmt_last;
    logic mod_busy;
  } wrhv_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/wav_riff_header_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_header_validator_top
// Streams a WAV file one byte per beat and returns one verdict beat on the
// byte flagged as last: validity, data payload offset/length and PCM format.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_file_byte, in_final_byte
//   out_     output     out_valid / out_stall is_valid, payload_offset/length,
//                                             channel_count, samples_per_second,
//                                             sample_bits
//
// One byte per cycle while parsing, unless in_stall holds the input.
// Last fmt payload byte: input stalls in ST_FMT1/ST_FMT2 for the fmt multiply check.
// Last file byte: the verdict is registered from ST_FIN after the frame remainder
// unit (started at the data header) is done and the output register is free.
// Reset clears the parser; the next byte after a verdict starts a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_header_validator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_valid,
  output logic [32:0]      out_payload_offset,
  output logic [31:0]      out_payload_length,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_samples_per_second,
  output logic [15:0]      out_sample_bits
);

  wrhv_pkg::wrhv_cmd_t cmd;
  wrhv_pkg::wrhv_sts_t sts;

  wrhv_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_byte (in_final_byte),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts)
  );

  wrhv_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_file_byte           (in_file_byte),
    .in_final_byte          (in_final_byte),
    .out_is_valid           (out_is_valid),
    .out_payload_offset     (out_payload_offset),
    .out_payload_length     (out_payload_length),
    .out_channel_count      (out_channel_count),
    .out_samples_per_second (out_samples_per_second),
    .out_sample_bits        (out_sample_bits)
  );

endmodule

`default_nettype wire

// File: hw/rtl/wrhv_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhv_dpath
// Byte parser, fmt check steps, frame remainder unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrhv_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wrhv_pkg::wrhv_cmd_t cmd,
  output wrhv_pkg::wrhv_sts_t     sts,
  input  wire logic [7:0]         in_file_byte,
  input  wire logic               in_final_byte,
  output logic                    out_is_valid,
  output logic [32:0]             out_payload_offset,
  output logic [31:0]             out_payload_length,
  output logic [15:0]             out_channel_count,
  output logic [31:0]             out_samples_per_second,
  output logic [15:0]             out_sample_bits
);

  logic [32:0]  pos_r, pos_nxt;
  logic [31:0]  clen_r, clen_nxt;
  logic [33:0]  ncp_r, ncp_nxt;
  logic [31:0]  tag_r, tag_nxt;
  logic [31:0]  len_r, len_nxt;
  logic [1:0]   phase_r, phase_nxt;
  logic         fmt_seen_r, fmt_seen_nxt;
  logic [1:0]   verd_r, verd_nxt;
  logic [127:0] ff_r, ff_nxt;
  logic [32:0]  foff_r, foff_nxt;
  logic [31:0]  flen_r, flen_nxt;
  logic [33:0]  dend_r, dend_nxt;
  logic [28:0]  xalign_r, xalign_nxt;
  logic         basic_bad_r, basic_bad_nxt;
  logic [5:0]   mod_cnt_r, mod_cnt_nxt;
  logic [31:0]  mod_q_r, mod_q_nxt;
  logic [15:0]  mod_rem_r, mod_rem_nxt;
  logic [15:0]  mod_d_r, mod_d_nxt;

  logic         o_valid_r, o_valid_nxt;
  logic [32:0]  o_off_r, o_off_nxt;
  logic [31:0]  o_len_r, o_len_nxt;
  logic [15:0]  o_ch_r, o_ch_nxt;
  logic [31:0]  o_rate_r, o_rate_nxt;
  logic [15:0]  o_bits_r, o_bits_nxt;

  logic        hdr_go;
  logic [2:0]  rel;
  logic [3:0]  fidx;
  logic [31:0] tag_sh;
  logic [31:0] len_sh;
  logic [33:0] skip_sum;
  logic [33:0] ncp_plus8;
  logic [15:0] f_fmt;
  logic [15:0] f_ch;
  logic [31:0] f_rate;
  logic [31:0] f_brate;
  logic [15:0] f_balign;
  logic [15:0] f_bits;
  logic [31:0] brate_prod;
  logic [16:0] mod_trial;
  logic [15:0] mod_rem_step;
  logic [33:0] size;
  logic        ok;

  always_comb begin
    hdr_go     = (phase_r == wrhv_pkg::PH_HDR) ||
                 ((phase_r == wrhv_pkg::PH_SKIP) && ({1'b0, pos_r} == ncp_r));
    rel        = pos_r[2:0] - ncp_r[2:0];
    fidx       = pos_r[3:0] - ncp_r[3:0];
    tag_sh     = {in_file_byte, tag_r[31:8]};
    len_sh     = {in_file_byte, len_r[31:8]};
    ncp_plus8  = ncp_r + wrhv_pkg::HDR_BYTES;
    skip_sum   = ncp_r + {2'b00, len_sh} + {30'd0, 1'b1, 2'b00, len_sh[0]};
    f_fmt      = ff_r[15:0];
    f_ch       = ff_r[31:16];
    f_rate     = ff_r[63:32];
    f_brate    = ff_r[95:64];
    f_balign   = ff_r[111:96];
    f_bits     = ff_r[127:112];
    brate_prod = f_rate * {3'd0, xalign_r};
    mod_trial  = {mod_rem_r, mod_q_r[31]};
    mod_rem_step = (mod_trial >= {1'b0, mod_d_r}) ?
                   16'(mod_trial - {1'b0, mod_d_r}) : mod_trial[15:0];
    size       = {1'b0, pos_r} + 34'd1;
    ok         = (verd_r == wrhv_pkg::VERD_DATA) &&
                 (pos_r >= wrhv_pkg::MIN_LAST_POS) &&
                 (({2'b00, clen_r} + 34'd7) == {1'b0, pos_r}) &&
                 (dend_r <= size);
  end

  always_comb begin
    pos_nxt       = pos_r;
    clen_nxt      = clen_r;
    ncp_nxt       = ncp_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    phase_nxt     = phase_r;
    fmt_seen_nxt  = fmt_seen_r;
    verd_nxt      = verd_r;
    ff_nxt        = ff_r;
    foff_nxt      = foff_r;
    flen_nxt      = flen_r;
    dend_nxt      = dend_r;
    xalign_nxt    = xalign_r;
    basic_bad_nxt = basic_bad_r;
    mod_cnt_nxt   = mod_cnt_r;
    mod_q_nxt     = mod_q_r;
    mod_rem_nxt   = mod_rem_r;
    mod_d_nxt     = mod_d_r;
    o_valid_nxt   = o_valid_r;
    o_off_nxt     = o_off_r;
    o_len_nxt     = o_len_r;
    o_ch_nxt      = o_ch_r;
    o_rate_nxt    = o_rate_r;
    o_bits_nxt    = o_bits_r;

    if (cmd.byte_en) begin
      if (verd_r == wrhv_pkg::VERD_NONE) begin
        unique case (phase_r)
          wrhv_pkg::PH_RIFF: begin
            if (pos_r < 33'd4) begin
              tag_nxt = tag_sh;
              if ((pos_r == 33'd3) && (tag_sh != wrhv_pkg::TAG_RIFF)) begin
                verd_nxt = wrhv_pkg::VERD_FAIL;
              end
            end else if (pos_r < 33'd8) begin
              clen_nxt = {in_file_byte, clen_r[31:8]};
            end else begin
              tag_nxt = tag_sh;
              if (pos_r == 33'd11) begin
                if (tag_sh != wrhv_pkg::TAG_WAVE) begin
                  verd_nxt = wrhv_pkg::VERD_FAIL;
                end
                phase_nxt = wrhv_pkg::PH_SKIP;
                ncp_nxt   = wrhv_pkg::FIRST_CHUNK;
              end
            end
          end
          wrhv_pkg::PH_FMT: begin
            ff_nxt = {in_file_byte, ff_r[127:8]};
            if (fidx == 4'd15) begin
              phase_nxt = wrhv_pkg::PH_SKIP;
            end
          end
          default: begin
            if (hdr_go) begin
              phase_nxt = wrhv_pkg::PH_HDR;
              if (rel < 3'd4) begin
                tag_nxt = tag_sh;
              end else begin
                len_nxt = len_sh;
              end
              if (rel == 3'd7) begin
                if (!fmt_seen_r && (tag_r == wrhv_pkg::TAG_FMT)) begin
                  if (len_sh != wrhv_pkg::FMT_BYTES) begin
                    verd_nxt = wrhv_pkg::VERD_FAIL;
                  end else begin
                    ncp_nxt   = ncp_r + wrhv_pkg::FMT_SPAN;
                    phase_nxt = wrhv_pkg::PH_FMT;
                  end
                end else if (tag_r == wrhv_pkg::TAG_DATA) begin
                  if (!fmt_seen_r) begin
                    verd_nxt = wrhv_pkg::VERD_FAIL;
                  end else begin
                    foff_nxt    = ncp_plus8[32:0];
                    flen_nxt    = len_sh;
                    verd_nxt    = wrhv_pkg::VERD_DATA;
                    mod_cnt_nxt = wrhv_pkg::MOD_STEPS;
                    mod_q_nxt   = len_sh;
                    mod_rem_nxt = '0;
                    mod_d_nxt   = f_balign;
                  end
                end else begin
                  ncp_nxt   = skip_sum;
                  phase_nxt = wrhv_pkg::PH_SKIP;
                end
              end
            end
          end
        endcase
      end
      if (!in_final_byte && (pos_r != wrhv_pkg::POS_MAX)) begin
        pos_nxt = pos_r + 33'd1;
      end
    end

    if (cmd.fmt_s1) begin
      basic_bad_nxt = (f_fmt != 16'd1) || (f_ch == 16'd0) || (f_rate == 32'd0) ||
                      (f_bits == 16'd0) || (f_bits[2:0] != 3'd0);
      xalign_nxt    = {13'd0, f_ch} * {16'd0, f_bits[15:3]};
    end

    if (cmd.fmt_s2) begin
      if (basic_bad_r || ({13'd0, f_balign} != xalign_r) || (f_brate != brate_prod)) begin
        verd_nxt = wrhv_pkg::VERD_FAIL;
      end else begin
        fmt_seen_nxt = 1'b1;
      end
    end

    if (mod_cnt_r != 6'd0) begin
      mod_cnt_nxt = mod_cnt_r - 6'd1;
      mod_q_nxt   = {mod_q_r[30:0], 1'b0};
      mod_rem_nxt = mod_rem_step;
      dend_nxt    = {1'b0, foff_r} + {2'b00, flen_r};
      if ((mod_cnt_r == 6'd1) && (mod_rem_step != 16'd0)) begin
        verd_nxt = wrhv_pkg::VERD_FAIL;
      end
    end

    if (cmd.finish) begin
      o_valid_nxt  = ok;
      o_off_nxt    = ok ? foff_r : '0;
      o_len_nxt    = ok ? flen_r : '0;
      o_ch_nxt     = ok ? f_ch : '0;
      o_rate_nxt   = ok ? f_rate : '0;
      o_bits_nxt   = ok ? f_bits : '0;
      pos_nxt      = '0;
      clen_nxt     = '0;
      ncp_nxt      = wrhv_pkg::FIRST_CHUNK;
      tag_nxt      = '0;
      len_nxt      = '0;
      phase_nxt    = wrhv_pkg::PH_RIFF;
      fmt_seen_nxt = 1'b0;
      verd_nxt     = wrhv_pkg::VERD_NONE;
      mod_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      clen_r     <= '0;
      ncp_r      <= wrhv_pkg::FIRST_CHUNK;
      tag_r      <= '0;
      len_r      <= '0;
      phase_r    <= wrhv_pkg::PH_RIFF;
      fmt_seen_r <= 1'b0;
      verd_r     <= wrhv_pkg::VERD_NONE;
      mod_cnt_r  <= '0;
    end else begin
      pos_r      <= pos_nxt;
      clen_r     <= clen_nxt;
      ncp_r      <= ncp_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      phase_r    <= phase_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      verd_r     <= verd_nxt;
      mod_cnt_r  <= mod_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ff_r        <= ff_nxt;
    foff_r      <= foff_nxt;
    flen_r      <= flen_nxt;
    dend_r      <= dend_nxt;
    xalign_r    <= xalign_nxt;
    basic_bad_r <= basic_bad_nxt;
    mod_q_r     <= mod_q_nxt;
    mod_rem_r   <= mod_rem_nxt;
    mod_d_r     <= mod_d_nxt;
    o_valid_r   <= o_valid_nxt;
    o_off_r     <= o_off_nxt;
    o_len_r     <= o_len_nxt;
    o_ch_r      <= o_ch_nxt;
    o_rate_r    <= o_rate_nxt;
    o_bits_r    <= o_bits_nxt;
  end

  assign sts = {(verd_r == wrhv_pkg::VERD_NONE) &&
                (phase_r == wrhv_pkg::PH_FMT) && (fidx == 4'd15),
                (mod_cnt_r != 6'd0)};

  assign out_is_valid           = o_valid_r;
  assign out_payload_offset     = o_off_r;
  assign out_payload_length     = o_len_r;
  assign out_channel_count      = o_ch_r;
  assign out_samples_per_second = o_rate_r;
  assign out_sample_bits        = o_bits_r;

  a_verd_code: assert property (@(posedge clk) disable iff (!rst_n)
    verd_r != 2'd3)
    else $error("verdict register holds an unused code");

  a_mod_after_data: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_cnt_r != 6'd0) |-> (verd_r == wrhv_pkg::VERD_DATA) ||
                            (verd_r == wrhv_pkg::VERD_FAIL))
    else $error("remainder unit running without a data chunk");

  a_fmt_once: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wrhv_pkg::PH_FMT) |-> !fmt_seen_r)
    else $error("second fmt payload parsed");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (mod_cnt_r == 6'd0) && !cmd.byte_en)
    else $error("verdict taken while remainder unit busy");

endmodule

`default_nettype wire

// File: hw/rtl/wrhv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhv_ctrl
// Sequencer: byte intake, two-step fmt check, verdict and result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module wrhv_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_final_byte,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wrhv_pkg::wrhv_cmd_t      cmd,
  input  wire wrhv_pkg::wrhv_sts_t sts
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_FMT1 = 2'd1;
  localparam logic [1:0] ST_FMT2 = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       fin_pend_r, fin_pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  always_comb begin
    accept       = in_valid && (state_r == ST_RUN);
    state_nxt    = state_r;
    fin_pend_nxt = fin_pend_r;
    cmd          = '0;
    cmd.byte_en  = accept;

    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (sts.fmt_last) begin
            state_nxt    = ST_FMT1;
            fin_pend_nxt = in_final_byte;
          end else if (in_final_byte) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FMT1: begin
        cmd.fmt_s1 = 1'b1;
        state_nxt  = ST_FMT2;
      end
      ST_FMT2: begin
        cmd.fmt_s2 = 1'b1;
        state_nxt  = fin_pend_r ? ST_FIN : ST_RUN;
      end
      default: begin
        if (!sts.mod_busy && (!out_valid_r || !out_stall)) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_pend_r  <= fin_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_RUN);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
